// ===== rtl/core/vmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_pkg - shared definitions for the vending machine controller
// Field widths, mode and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package vmc_pkg;

    localparam int DEFAULT_MAX_SLOTS = 16;

    localparam int MODE_W  = 3;
    localparam int SLOT_W  = 4;
    localparam int COIN_W  = 10;
    localparam int QTY_W   = 8;
    localparam int PRICE_W = 16;
    localparam int STAT_W  = 3;

    // table word: stock in the upper byte, price below
    localparam int WORD_W  = QTY_W + PRICE_W;

    localparam logic [MODE_W-1:0] MODE_SELECT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COIN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 3'd5;

    localparam logic [STAT_W-1:0] ST_AWAIT    = 3'd0;
    localparam logic [STAT_W-1:0] ST_DISPENSE = 3'd1;
    localparam logic [STAT_W-1:0] ST_SOLD_OUT = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_SLOT = 3'd3;
    localparam logic [STAT_W-1:0] ST_CANCEL   = 3'd4;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd5;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd6;
    localparam logic [STAT_W-1:0] ST_WRONG    = 3'd7;

    typedef struct packed {
        logic latch;     // capture the input beat
        logic rd_issue;  // read the table entry the item refers to
        logic eval;      // decide the result and update state
        logic sh_rd;     // read the entry above the delete pointer
        logic sh_wr;     // write it one place down
        logic out_load;  // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic del_start;   // delete accepted, shift pass follows
        logic shift_more;  // entries left to move down
    } sts_t;

endpackage

// ===== rtl/core/vmc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_datapath - slot table, billing registers and result registers
// Holds the stock/price memory, the billing state and the result path;
// every step is driven by commands from the controller.
// ----------------------------------------------------------------------------
module vmc_datapath #(
    parameter int MAX_SLOTS = vmc_pkg::DEFAULT_MAX_SLOTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vmc_pkg::cmd_t               cmd,
    output vmc_pkg::sts_t               sts,
    input  logic [vmc_pkg::MODE_W-1:0]  mode,
    input  logic [vmc_pkg::SLOT_W-1:0]  slot,
    input  logic [vmc_pkg::COIN_W-1:0]  coin_value,
    input  logic [vmc_pkg::QTY_W-1:0]   new_quantity,
    input  logic [vmc_pkg::PRICE_W-1:0] new_price,
    output logic [vmc_pkg::STAT_W-1:0]  status,
    output logic [vmc_pkg::PRICE_W-1:0] amount_due,
    output logic [vmc_pkg::PRICE_W-1:0] change_out,
    output logic [vmc_pkg::SLOT_W-1:0]  dispensed_slot,
    output logic [vmc_pkg::QTY_W-1:0]   stock_left
);
    import vmc_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_SLOTS);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SLOTS);

    logic [WORD_W-1:0] mem [MAX_SLOTS];

    // latched input beat
    logic [MODE_W-1:0]  mode_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [COIN_W-1:0]  coin_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [PRICE_W-1:0] price_reg;

    logic               billing_reg,  billing_next;
    logic [SLOT_W-1:0]  selected_reg, selected_next;
    logic [PRICE_W-1:0] paid_reg,     paid_next;
    logic [CW-1:0]      count_reg,    count_next;
    logic [CW-1:0]      ptr_reg,      ptr_next;
    logic [WORD_W-1:0]  rd_data_reg;

    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [PRICE_W-1:0] res_due_reg,    res_due_next;
    logic [PRICE_W-1:0] res_change_reg, res_change_next;
    logic [SLOT_W-1:0]  res_slot_reg,   res_slot_next;
    logic [QTY_W-1:0]   res_stock_reg,  res_stock_next;

    logic [STAT_W-1:0]  status_reg;
    logic [PRICE_W-1:0] due_reg;
    logic [PRICE_W-1:0] change_reg;
    logic [SLOT_W-1:0]  dslot_reg;
    logic [QTY_W-1:0]   stock_reg;

    logic [XW-1:0]      slot_x, sel_x, cnt_x;
    logic [AW-1:0]      slot_idx, sel_idx, rd_addr, wr_addr;
    logic [CW-1:0]      ptr_inc;
    logic [WORD_W-1:0]  wr_data;
    logic               wr_en, rd_en;
    logic               slot_bad, table_full, wrong_phase, pay_mode, del_start;
    logic [QTY_W-1:0]   sd, stock_dec;
    logic [PRICE_W-1:0] pd, paid_sat;
    logic [PRICE_W:0]   paid_sum;

    assign slot_x     = XW'(slot_reg);
    assign sel_x      = XW'(selected_reg);
    assign cnt_x      = XW'(count_reg);
    assign slot_idx   = (slot_x < MAX_X) ? slot_x[AW-1:0] : '0;
    assign sel_idx    = (sel_x < MAX_X) ? sel_x[AW-1:0] : '0;
    assign ptr_inc    = ptr_reg + 1'b1;
    assign slot_bad   = (slot_x >= cnt_x);
    assign table_full = (count_reg >= MAX_C);
    assign pay_mode   = (mode_reg == MODE_COIN) || (mode_reg == MODE_CANCEL);
    assign wrong_phase = (mode_reg > MODE_MODIFY) || (billing_reg != pay_mode);

    assign sd        = rd_data_reg[WORD_W-1:PRICE_W];
    assign pd        = rd_data_reg[PRICE_W-1:0];
    assign stock_dec = (sd != '0) ? sd - 1'b1 : sd;
    assign paid_sum  = {1'b0, paid_reg} + (PRICE_W+1)'(coin_reg);
    assign paid_sat  = paid_sum[PRICE_W] ? {PRICE_W{1'b1}} : paid_sum[PRICE_W-1:0];

    assign rd_en   = cmd.rd_issue | cmd.sh_rd;
    assign rd_addr = cmd.sh_rd ? ptr_inc[AW-1:0] : (pay_mode ? sel_idx : slot_idx);

    always_comb
    begin
        billing_next    = billing_reg;
        selected_next   = selected_reg;
        paid_next       = paid_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_due_next    = res_due_reg;
        res_change_next = res_change_reg;
        res_slot_next   = res_slot_reg;
        res_stock_next  = res_stock_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        del_start       = 1'b0;

        if (cmd.eval)
        begin
            res_status_next = ST_WRONG;
            res_due_next    = '0;
            res_change_next = '0;
            res_slot_next   = '0;
            res_stock_next  = '0;
            if (!wrong_phase)
            begin
                case (mode_reg)
                    MODE_SELECT:
                    begin
                        res_slot_next = slot_reg;
                        if (slot_bad)
                            res_status_next = ST_BAD_SLOT;
                        else if (sd == '0)
                            res_status_next = ST_SOLD_OUT;
                        else
                        begin
                            selected_next = slot_reg;
                            paid_next     = '0;
                            if (pd == '0)
                            begin
                                // free item: dispense without billing
                                wr_en           = 1'b1;
                                wr_addr         = slot_idx;
                                wr_data         = {stock_dec, pd};
                                res_status_next = ST_DISPENSE;
                                res_stock_next  = stock_dec;
                            end
                            else
                            begin
                                billing_next    = 1'b1;
                                res_status_next = ST_AWAIT;
                                res_due_next    = pd;
                                res_stock_next  = sd;
                            end
                        end
                    end
                    MODE_COIN:
                    begin
                        res_slot_next = selected_reg;
                        if (paid_sat >= pd)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = sel_idx;
                            wr_data         = {stock_dec, pd};
                            billing_next    = 1'b0;
                            paid_next       = '0;
                            res_status_next = ST_DISPENSE;
                            res_change_next = paid_sat - pd;
                            res_stock_next  = stock_dec;
                        end
                        else
                        begin
                            paid_next       = paid_sat;
                            res_status_next = ST_AWAIT;
                            res_due_next    = pd - paid_sat;
                            res_stock_next  = sd;
                        end
                    end
                    MODE_CANCEL:
                    begin
                        billing_next    = 1'b0;
                        paid_next       = '0;
                        res_status_next = ST_CANCEL;
                        res_change_next = paid_reg;
                        res_slot_next   = selected_reg;
                        res_stock_next  = sd;
                    end
                    MODE_ADD:
                    begin
                        if (table_full)
                            res_status_next = ST_FULL;
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = count_reg[AW-1:0];
                            wr_data         = {qty_reg, price_reg};
                            res_status_next = ST_UPDATED;
                            res_slot_next   = cnt_x[SLOT_W-1:0];
                            res_stock_next  = qty_reg;
                            count_next      = count_reg + 1'b1;
                        end
                    end
                    MODE_DELETE:
                    begin
                        res_slot_next = slot_reg;
                        if (slot_bad)
                            res_status_next = ST_BAD_SLOT;
                        else
                        begin
                            // stock_left is filled in by the first shift, if any
                            res_status_next = ST_UPDATED;
                            count_next      = count_reg - 1'b1;
                            ptr_next        = slot_x[CW-1:0];
                            del_start       = 1'b1;
                        end
                    end
                    MODE_MODIFY:
                    begin
                        res_slot_next = slot_reg;
                        if (slot_bad)
                            res_status_next = ST_BAD_SLOT;
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = slot_idx;
                            wr_data         = {qty_reg, price_reg};
                            res_status_next = ST_UPDATED;
                            res_stock_next  = qty_reg;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_WRONG;
                    end
                endcase
            end
        end

        if (cmd.sh_wr)
        begin
            wr_en    = 1'b1;
            wr_addr  = ptr_reg[AW-1:0];
            wr_data  = rd_data_reg;
            ptr_next = ptr_inc;
            if (ptr_reg == slot_x[CW-1:0])
                res_stock_next = sd;
        end
    end

    assign sts.del_start  = del_start;
    assign sts.shift_more = (ptr_reg < count_reg);

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            billing_reg  <= 1'b0;
            selected_reg <= '0;
            paid_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            billing_reg  <= billing_next;
            selected_reg <= selected_next;
            paid_reg     <= paid_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg  <= mode;
            slot_reg  <= slot;
            coin_reg  <= coin_value;
            qty_reg   <= new_quantity;
            price_reg <= new_price;
        end
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_due_reg    <= res_due_next;
        res_change_reg <= res_change_next;
        res_slot_reg   <= res_slot_next;
        res_stock_reg  <= res_stock_next;
        if (cmd.out_load)
        begin
            status_reg <= res_status_reg;
            due_reg    <= res_due_reg;
            change_reg <= res_change_reg;
            dslot_reg  <= res_slot_reg;
            stock_reg  <= res_stock_reg;
        end
    end

    assign status         = status_reg;
    assign amount_due     = due_reg;
    assign change_out     = change_reg;
    assign dispensed_slot = dslot_reg;
    assign stock_left     = stock_reg;

endmodule

// ===== rtl/core/vmc_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_controller - sequencing state machine
// Steps each item through read, evaluate and the delete shift pass, and
// owns both handshakes.
// ----------------------------------------------------------------------------
module vmc_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    output logic          result_valid,
    input  logic          result_stall,
    input  vmc_pkg::sts_t sts,
    output vmc_pkg::cmd_t cmd
);
    import vmc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.del_start ? S_SHRD : S_DONE;
            end
            S_SHRD:
            begin
                if (sts.shift_more)
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SHWR;
                end
                else
                    state_next = S_DONE;
            end
            S_SHWR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SHRD;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

// ===== rtl/core/vending_machine_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vending_machine_controller_top - vending machine controller
// Slot table of stock and price with select, coin, cancel and table
// maintenance (add, delete, modify); one result beat per input beat.
// ----------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   -------   ------------------------   ----------------------------------------
//   item      item_valid / item_stall    mode slot coin_value new_quantity new_price
//   result    result_valid / result_stall status amount_due change_out
//                                        dispensed_slot stock_left
//
// Sequence: an item holds the sequencer through accept and latch, table
// read, evaluate and load output; its result beat shows once the output
// register is loaded. Delete adds a shift pass that moves each entry above
// the deleted slot one place down, with a registered table read and then a
// write for each entry, before the pass closes.
// Reset: rst_n clears the billing state, the item count and both handshakes;
// the table contents stay undefined until written.
// Stalls: a finished result waits in the output register while the next
// item is accepted and worked on; only a second result blocks on it.
//
module vending_machine_controller_top #(
    parameter int MAX_SLOTS = vmc_pkg::DEFAULT_MAX_SLOTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [vmc_pkg::MODE_W-1:0]  mode,
    input  logic [vmc_pkg::SLOT_W-1:0]  slot,
    input  logic [vmc_pkg::COIN_W-1:0]  coin_value,
    input  logic [vmc_pkg::QTY_W-1:0]   new_quantity,
    input  logic [vmc_pkg::PRICE_W-1:0] new_price,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [vmc_pkg::STAT_W-1:0]  status,
    output logic [vmc_pkg::PRICE_W-1:0] amount_due,
    output logic [vmc_pkg::PRICE_W-1:0] change_out,
    output logic [vmc_pkg::SLOT_W-1:0]  dispensed_slot,
    output logic [vmc_pkg::QTY_W-1:0]   stock_left
);
    import vmc_pkg::*;

    // command and status bundles between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: owns both handshakes and the delete shift loop
    vmc_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    // datapath: slot table memory, billing registers, result register
    vmc_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .mode           (mode),
        .slot           (slot),
        .coin_value     (coin_value),
        .new_quantity   (new_quantity),
        .new_price      (new_price),
        .status         (status),
        .amount_due     (amount_due),
        .change_out     (change_out),
        .dispensed_slot (dispensed_slot),
        .stock_left     (stock_left)
    );

endmodule

// ===== rtl/core/vmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_checker - port-level checks for the vending machine controller
// Watches the top-level ports; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module vmc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic [vmc_pkg::STAT_W-1:0]  status,
    input logic [vmc_pkg::PRICE_W-1:0] amount_due,
    input logic [vmc_pkg::PRICE_W-1:0] change_out,
    input logic [vmc_pkg::SLOT_W-1:0]  dispensed_slot,
    input logic [vmc_pkg::QTY_W-1:0]   stock_left
);
    import vmc_pkg::*;

    // a stalled result beat stays
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status)
            && $stable(change_out))
        else $error("stalled result beat changed");

    // an accepted item keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input not stalled after accept");

    // a rejected item reports nothing but its status
    a_wrong_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_WRONG |-> amount_due == '0
            && change_out == '0 && dispensed_slot == '0 && stock_left == '0)
        else $error("wrong-phase result carries data");

    // a dispense leaves nothing due
    a_dispense_paid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_DISPENSE |-> amount_due == '0)
        else $error("dispense with amount still due");

endmodule

bind vending_machine_controller_top vmc_checker u_vmc_checker (.*);
